### hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and controller/datapath interface types for the serial
// frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // Payload buffer geometry
   localparam int PAYLOAD_DEPTH = 16;
   localparam int IDX_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);

   // Frame constants
   localparam logic [7:0] SYNC_BYTE = 8'hAA;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BADSUM   = 2'd1;
   localparam logic [1:0] STATUS_OVERSIZE = 2'd2;

   // Result kinds requested by the controller
   localparam logic [2:0] EMIT_NONE     = 3'd0;
   localparam logic [2:0] EMIT_OVERSIZE = 3'd1;
   localparam logic [2:0] EMIT_BADSUM   = 3'd2;
   localparam logic [2:0] EMIT_EMPTY    = 3'd3;
   localparam logic [2:0] EMIT_DATA     = 3'd4;

   // Controller -> datapath commands
   typedef struct packed {
      logic       clr_command;
      logic       ld_command;
      logic       ld_length;
      logic       wr_payload;
      logic       drain_clr;
      logic [2:0] emit;
   } cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic byte_sync;
      logic cmd_ok;
      logic len_over;
      logic byte_zero;
      logic pay_done;
      logic sum_ok;
      logic len_zero;
      logic drain_last;
      logic out_free;
   } stat_type;

endpackage

### hw/rtl/sfr_datapath.sv
// ----------------------------------------------------------------------------
// sfr_datapath
// Frame fields, payload buffer, running checksum, drain pointer and the
// result output register.
// ----------------------------------------------------------------------------
module sfr_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   input  logic [7:0]        rx_byte,
   input  logic              rsp_ready,
   input  sfr_pkg::cmd_type  cmd,
   output sfr_pkg::stat_type stat,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_command,
   output logic [7:0]        rsp_length,
   output logic [3:0]        rsp_byte_index,
   output logic [7:0]        rsp_payload_byte,
   output logic              rsp_has_data,
   output logic              rsp_last
);
   import sfr_pkg::*;

   logic [7:0]       exp_cmd_ff, exp_cmd_in;
   logic [7:0]       frame_cmd_ff, frame_cmd_in;
   logic [7:0]       frame_len_ff, frame_len_in;
   logic [CNT_W-1:0] rcv_cnt_ff, rcv_cnt_in;
   logic [7:0]       sum_ff, sum_in;
   logic [IDX_W-1:0] drain_idx_ff, drain_idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_status_ff;
   logic [7:0]       out_command_ff;
   logic [7:0]       out_length_ff;
   logic [3:0]       out_index_ff;
   logic [7:0]       out_payload_ff;
   logic             out_has_ff;
   logic             out_last_ff;
   logic [7:0]       payload_mem [PAYLOAD_DEPTH];
   logic             emit_any;
   logic             emit_data;

   assign emit_any  = (cmd.emit != EMIT_NONE);
   assign emit_data = (cmd.emit == EMIT_DATA);

   // Status back to the controller
   always_comb begin
      stat.byte_sync  = (rx_byte == SYNC_BYTE);
      stat.cmd_ok     = (exp_cmd_ff == 8'd0) || (exp_cmd_ff == rx_byte);
      stat.len_over   = (rx_byte > 8'(PAYLOAD_DEPTH));
      stat.byte_zero  = (rx_byte == 8'd0);
      stat.pay_done   = ((9'(rcv_cnt_ff) + 9'd1) == 9'(frame_len_ff));
      stat.sum_ok     = (rx_byte == ~sum_ff);
      stat.len_zero   = (frame_len_ff == 8'd0);
      stat.drain_last = ((9'(drain_idx_ff) + 9'd1) == 9'(frame_len_ff));
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

   // Next-state for frame fields, counters and checksum
   always_comb begin
      exp_cmd_in   = csr_wr_en ? csr_wr_data : exp_cmd_ff;
      frame_cmd_in = frame_cmd_ff;
      frame_len_in = frame_len_ff;
      rcv_cnt_in   = rcv_cnt_ff;
      sum_in       = sum_ff;
      drain_idx_in = drain_idx_ff;
      if (cmd.clr_command) begin
         frame_cmd_in = 8'd0;
      end
      if (cmd.ld_command) begin
         frame_cmd_in = rx_byte;
      end
      if (cmd.ld_length) begin
         frame_len_in = rx_byte;
         rcv_cnt_in   = '0;
         sum_in       = 8'd0;
      end
      if (cmd.wr_payload) begin
         rcv_cnt_in = rcv_cnt_ff + CNT_W'(1);
         sum_in     = sum_ff + rx_byte;
      end
      if (cmd.drain_clr) begin
         drain_idx_in = '0;
      end else if (emit_data) begin
         drain_idx_in = drain_idx_ff + IDX_W'(1);
      end
   end

   // Output register valid: set on load, cleared when taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit_any) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control and field registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_cmd_ff   <= 8'd0;
         frame_cmd_ff <= 8'd0;
         frame_len_ff <= 8'd0;
         rcv_cnt_ff   <= '0;
         sum_ff       <= 8'd0;
         drain_idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         exp_cmd_ff   <= exp_cmd_in;
         frame_cmd_ff <= frame_cmd_in;
         frame_len_ff <= frame_len_in;
         rcv_cnt_ff   <= rcv_cnt_in;
         sum_ff       <= sum_in;
         drain_idx_ff <= drain_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload buffer write
   always_ff @(posedge clock) begin
      if (cmd.wr_payload && (rcv_cnt_ff < CNT_W'(PAYLOAD_DEPTH))) begin
         payload_mem[rcv_cnt_ff[IDX_W-1:0]] <= rx_byte;
      end
   end

   // Result word load, with registered buffer read
   always_ff @(posedge clock) begin
      if (emit_any) begin
         case (cmd.emit)
            EMIT_OVERSIZE: out_status_ff <= STATUS_OVERSIZE;
            EMIT_BADSUM:   out_status_ff <= STATUS_BADSUM;
            default:       out_status_ff <= STATUS_OK;
         endcase
         out_command_ff <= frame_cmd_ff;
         out_length_ff  <= (cmd.emit == EMIT_OVERSIZE) ? rx_byte : frame_len_ff;
         out_has_ff     <= emit_data;
         if (emit_data) begin
            out_index_ff   <= 4'(drain_idx_ff);
            out_payload_ff <= payload_mem[drain_idx_ff];
            out_last_ff    <= stat.drain_last;
         end else begin
            out_index_ff   <= 4'd0;
            out_payload_ff <= 8'd0;
            out_last_ff    <= 1'b1;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_command      = out_command_ff;
   assign rsp_length       = out_length_ff;
   assign rsp_byte_index   = out_index_ff;
   assign rsp_payload_byte = out_payload_ff;
   assign rsp_has_data     = out_has_ff;
   assign rsp_last         = out_last_ff;

endmodule

### hw/rtl/sfr_ctrl.sv
// ----------------------------------------------------------------------------
// sfr_ctrl
// Frame parsing state machine: header hunt, command, length, payload,
// checksum and result drain.
// ----------------------------------------------------------------------------
module sfr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sfr_pkg::stat_type stat,
   output sfr_pkg::cmd_type  cmd
);
   import sfr_pkg::*;

   localparam logic [2:0] ST_HUNT  = 3'd0;
   localparam logic [2:0] ST_CMD   = 3'd1;
   localparam logic [2:0] ST_LEN   = 3'd2;
   localparam logic [2:0] ST_PAY   = 3'd3;
   localparam logic [2:0] ST_CHK   = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       hdr_seen_ff, hdr_seen_in;
   logic       acc;

   // Take a word only when not draining and the result slot is free
   assign req_ready = (state_ff != ST_DRAIN) && stat.out_free;
   assign acc       = req_valid && req_ready;

   // Next state and datapath commands
   always_comb begin
      state_in        = state_ff;
      hdr_seen_in     = hdr_seen_ff;
      cmd.clr_command = 1'b0;
      cmd.ld_command  = 1'b0;
      cmd.ld_length   = 1'b0;
      cmd.wr_payload  = 1'b0;
      cmd.drain_clr   = 1'b0;
      cmd.emit        = EMIT_NONE;
      case (state_ff)
         ST_CMD: begin
            if (acc) begin
               cmd.ld_command = 1'b1;
               state_in       = stat.cmd_ok ? ST_LEN : ST_HUNT;
            end
         end
         ST_LEN: begin
            if (acc) begin
               cmd.ld_length = 1'b1;
               if (stat.len_over) begin
                  cmd.emit = EMIT_OVERSIZE;
                  state_in = ST_HUNT;
               end else if (stat.byte_zero) begin
                  state_in = ST_CHK;
               end else begin
                  state_in = ST_PAY;
               end
            end
         end
         ST_PAY: begin
            if (acc) begin
               cmd.wr_payload = 1'b1;
               if (stat.pay_done) begin
                  state_in = ST_CHK;
               end
            end
         end
         ST_CHK: begin
            if (acc) begin
               state_in = ST_HUNT;
               if (!stat.sum_ok) begin
                  cmd.emit = EMIT_BADSUM;
               end else if (stat.len_zero) begin
                  cmd.emit = EMIT_EMPTY;
               end else begin
                  cmd.drain_clr = 1'b1;
                  state_in      = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // one buffered byte per free output slot
            if (stat.out_free) begin
               cmd.emit = EMIT_DATA;
               if (stat.drain_last) begin
                  state_in = ST_HUNT;
               end
            end
         end
         default: begin
            // header hunt; unused codes land here too
            if (acc) begin
               state_in = ST_HUNT;
               if (stat.byte_sync) begin
                  cmd.clr_command = 1'b1;
                  if (hdr_seen_ff) begin
                     hdr_seen_in = 1'b0;
                     state_in    = ST_CMD;
                  end else begin
                     hdr_seen_in = 1'b1;
                  end
               end else begin
                  hdr_seen_in = 1'b0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_HUNT;
         hdr_seen_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         hdr_seen_ff <= hdr_seen_in;
      end
   end

endmodule

### hw/rtl/serial_frame_receiver_core.sv
// Serial frame receiver. Parses frames of the form AA AA command length
// payload checksum. A received word is taken whenever the result register is
// empty or being read in that same cycle, and any result it causes sits in
// the output register from the next cycle. A good frame of N payload bytes
// (N up to 16) gives N result words, drained from the payload buffer one per
// cycle in which the output register is free. No received word is taken
// while draining. A zero-length frame, a bad checksum or an oversize length
// gives a single result word. A result waiting unread on the output holds
// off every received word until it is taken, whether or not that word would
// cause a result of its own.
// ----------------------------------------------------------------------------
// serial_frame_receiver_core
// Top level: controller state machine plus datapath.
// ----------------------------------------------------------------------------
module serial_frame_receiver_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_command,
   output logic [7:0] rsp_length,
   output logic [3:0] rsp_byte_index,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_data,
   output logic       rsp_last
);
   import sfr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Frame state machine
   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Buffer, checksum and result register
   sfr_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rx_byte          (req_rx_byte),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_command      (rsp_command),
      .rsp_length       (rsp_length),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_has_data     (rsp_has_data),
      .rsp_last         (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // No new word while a stalled result occupies the output
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("word accepted while result stalled");

   // Results without data always close the frame
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_data |-> rsp_last)
      else $error("dataless result not marked last");

   // Error results never carry payload
   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> !rsp_has_data && rsp_last)
      else $error("error result carries data");

   // A result with data that is not last is followed by the next index
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_has_data && !rsp_last
      |=> rsp_valid && rsp_has_data
          && (rsp_byte_index == $past(rsp_byte_index) + 4'd1))
      else $error("drain index did not advance");
`endif

endmodule
